/* hw/rtl/cpg_pkg.sv */
package cpg_pkg;

    // Field widths fixed by the interface
    localparam int C_W   = 16;
    localparam int R_W   = 12;
    localparam int Z_W   = 12;
    localparam int PT_W  = 21;

    // Product widths: signed center times zoom, radius times zoom
    localparam int PC_W  = C_W + Z_W + 1;
    localparam int RZ_W  = R_W + Z_W;

    localparam logic [Z_W-1:0] ZOOM_RESET = 12'd256;

    // Command queue between front and back
    localparam int QDEPTH = 2;
    localparam int QA_W   = $clog2(QDEPTH);

    typedef enum logic
    {
        OP_START = 1'b0,
        OP_STEP  = 1'b1
    } op_t;

    typedef struct packed
    {
        op_t                     op;
        logic signed [PC_W-1:0]  pcx;
        logic signed [PC_W-1:0]  pcy;
        logic [RZ_W-1:0]         rz;
    } cmd_t;

    typedef struct packed
    {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

/* hw/rtl/cpg_front.sv */
module cpg_front
    import cpg_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [Z_W-1:0]         cfg_wdata,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   op,
    input  logic signed [C_W-1:0]  center_x,
    input  logic signed [C_W-1:0]  center_y,
    input  logic [R_W-1:0]         radius,
    input  q_stat_t                q_stat,
    output logic                   push,
    output cmd_t                   wr_cmd
);

    logic [Z_W-1:0]        zoom_reg;
    logic [Z_W-1:0]        zoom_next;
    logic signed [Z_W:0]   zoom_s;

    // Zoom register
    always_comb
    begin
        zoom_next = zoom_reg;
        if (cfg_we)
        begin
            zoom_next = cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zoom_reg <= ZOOM_RESET;
        end
        else
        begin
            zoom_reg <= zoom_next;
        end
    end

    // Accept a transaction whenever the queue has room
    assign in_stall = q_stat.full;
    assign push     = in_valid && !q_stat.full;

    // Classify and scale; the raw products go into the queue
    assign zoom_s        = $signed({1'b0, zoom_reg});
    assign wr_cmd.op     = op_t'(op);
    assign wr_cmd.pcx    = PC_W'(center_x) * PC_W'(zoom_s);
    assign wr_cmd.pcy    = PC_W'(center_y) * PC_W'(zoom_s);
    assign wr_cmd.rz     = RZ_W'(radius) * RZ_W'(zoom_reg);

endmodule

/* hw/rtl/cpg_queue.sv */
module cpg_queue
    import cpg_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  cmd_t     wr_cmd,
    input  logic     pop,
    output cmd_t     rd_cmd,
    output q_stat_t  q_stat
);

    cmd_t              entry_reg [QDEPTH];
    logic [QA_W-1:0]   wr_ptr_reg;
    logic [QA_W-1:0]   wr_ptr_next;
    logic [QA_W-1:0]   rd_ptr_reg;
    logic [QA_W-1:0]   rd_ptr_next;
    logic [QA_W:0]     count_reg;
    logic [QA_W:0]     count_next;

    // Pointer and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QA_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QA_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store entries
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

    assign rd_cmd       = entry_reg[rd_ptr_reg];
    assign q_stat.full  = (count_reg == (QA_W + 1)'(QDEPTH));
    assign q_stat.empty = (count_reg == '0);

endmodule

/* hw/rtl/cpg_back.sv */
module cpg_back
    import cpg_pkg::*;
#(
    parameter int ZOOM_FRAC_BITS = 8
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  q_stat_t                 q_stat,
    input  cmd_t                    rd_cmd,
    output logic                    pop,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic signed [PT_W-1:0]  point_x,
    output logic signed [PT_W-1:0]  point_y,
    output logic                    last,
    output logic                    finished
);

    localparam int F      = ZOOM_FRAC_BITS;
    localparam int D_W    = RZ_W + 1 - F;
    localparam int OFF_W  = RZ_W - F + 2;
    localparam int ERR_W  = D_W + 3;
    localparam int STEP_W = D_W + 1;
    localparam logic signed [PC_W-1:0] BIAS = PC_W'((64'd1 << F) - 64'd1);
    localparam logic [2:0] LAST_IDX = 3'd7;

    // Circle state
    logic signed [PT_W-1:0]   cx_reg, cx_next;
    logic signed [PT_W-1:0]   cy_reg, cy_next;
    logic signed [OFF_W-1:0]  x_reg, x_next;
    logic signed [OFF_W-1:0]  y_reg, y_next;
    logic [STEP_W-1:0]        sx_reg, sx_next;
    logic [STEP_W-1:0]        sy_reg, sy_next;
    logic signed [ERR_W-1:0]  err_reg, err_next;
    logic [D_W-1:0]           d_reg, d_next;
    logic                     active_reg, active_next;

    // Emission control and output register
    logic                     emit_reg, emit_next;
    logic [2:0]               idx_reg, idx_next;
    logic signed [PT_W-1:0]   snap_x_reg, snap_x_next;
    logic signed [PT_W-1:0]   snap_y_reg, snap_y_next;
    logic                     ov_reg, ov_next;
    logic signed [PT_W-1:0]   px_reg, px_next;
    logic signed [PT_W-1:0]   py_reg, py_next;
    logic                     last_reg, last_next;
    logic                     fin_reg, fin_next;

    // Start decode
    logic signed [PC_W-1:0]   pcx_adj, pcy_adj;
    logic [RZ_W-1:0]          rz_int;
    logic [D_W-1:0]           d_new;
    logic signed [OFF_W-1:0]  x_new;

    // Step update
    logic                     out_free;
    logic                     fin_cond;
    logic signed [ERR_W-1:0]  e_a;
    logic signed [OFF_W-1:0]  x_upd, y_upd;
    logic [STEP_W-1:0]        sx_upd, sy_upd;
    logic signed [ERR_W-1:0]  e_upd;

    // Point select
    logic signed [PT_W-1:0]   src_x, src_y, a_off, b_off, pt_x, pt_y;
    logic [2:0]               sel_idx;

    assign out_free = !ov_reg || !out_stall;
    assign pop      = out_free && !emit_reg && !q_stat.empty;
    assign fin_cond = !active_reg || (x_reg < y_reg);

    // Scale the start command: truncate toward zero
    always_comb
    begin
        pcx_adj = rd_cmd.pcx + (rd_cmd.pcx[PC_W-1] ? BIAS : '0);
        pcy_adj = rd_cmd.pcy + (rd_cmd.pcy[PC_W-1] ? BIAS : '0);
        rz_int  = rd_cmd.rz >> F;
        d_new   = D_W'({rd_cmd.rz, 1'b0} >> F);
        x_new   = OFF_W'(rz_int)
                - (((rd_cmd.rz == '0) || (rz_int != '0)) ? OFF_W'(1) : OFF_W'(0));
    end

    // Midpoint error update
    always_comb
    begin
        e_a    = err_reg;
        y_upd  = y_reg;
        sy_upd = sy_reg;
        x_upd  = x_reg;
        sx_upd = sx_reg;
        if (err_reg <= 0)
        begin
            y_upd  = y_reg + OFF_W'(1);
            e_a    = err_reg + ERR_W'(sy_reg);
            sy_upd = sy_reg + STEP_W'(2);
        end
        e_upd = e_a;
        if (e_a > 0)
        begin
            x_upd  = x_reg - OFF_W'(1);
            sx_upd = sx_reg + STEP_W'(2);
            e_upd  = e_a + ERR_W'(sx_upd) - ERR_W'(d_reg);
        end
    end

    // Pick one of the eight octant points
    always_comb
    begin
        src_x   = emit_reg ? snap_x_reg : PT_W'(x_reg);
        src_y   = emit_reg ? snap_y_reg : PT_W'(y_reg);
        sel_idx = emit_reg ? idx_reg : 3'd0;
        a_off   = sel_idx[2] ? src_y : src_x;
        b_off   = sel_idx[2] ? src_x : src_y;
        pt_x    = sel_idx[1] ? cx_reg - a_off : cx_reg + a_off;
        pt_y    = sel_idx[0] ? cy_reg + b_off : cy_reg - b_off;
    end

    // Sequence commands and results
    always_comb
    begin
        cx_next     = cx_reg;
        cy_next     = cy_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        sx_next     = sx_reg;
        sy_next     = sy_reg;
        err_next    = err_reg;
        d_next      = d_reg;
        active_next = active_reg;
        emit_next   = emit_reg;
        idx_next    = idx_reg;
        snap_x_next = snap_x_reg;
        snap_y_next = snap_y_reg;
        ov_next     = ov_reg;
        px_next     = px_reg;
        py_next     = py_reg;
        last_next   = last_reg;
        fin_next    = fin_reg;
        if (out_free)
        begin
            ov_next = 1'b0;
            if (emit_reg)
            begin
                ov_next   = 1'b1;
                px_next   = pt_x;
                py_next   = pt_y;
                fin_next  = 1'b0;
                last_next = (idx_reg == LAST_IDX);
                idx_next  = idx_reg + 3'd1;
                if (idx_reg == LAST_IDX)
                begin
                    emit_next = 1'b0;
                end
            end
            else if (pop)
            begin
                case (rd_cmd.op)
                    OP_START:
                    begin
                        cx_next     = PT_W'(pcx_adj >>> F);
                        cy_next     = PT_W'(pcy_adj >>> F);
                        d_next      = d_new;
                        x_next      = x_new;
                        y_next      = '0;
                        sx_next     = STEP_W'(1);
                        sy_next     = STEP_W'(1);
                        err_next    = ERR_W'(1) - ERR_W'(d_new);
                        active_next = 1'b1;
                    end
                    OP_STEP:
                    begin
                        ov_next = 1'b1;
                        if (fin_cond)
                        begin
                            px_next     = '0;
                            py_next     = '0;
                            last_next   = 1'b1;
                            fin_next    = 1'b1;
                            active_next = 1'b0;
                        end
                        else
                        begin
                            px_next     = pt_x;
                            py_next     = pt_y;
                            last_next   = 1'b0;
                            fin_next    = 1'b0;
                            snap_x_next = PT_W'(x_reg);
                            snap_y_next = PT_W'(y_reg);
                            emit_next   = 1'b1;
                            idx_next    = 3'd1;
                            x_next      = x_upd;
                            y_next      = y_upd;
                            sx_next     = sx_upd;
                            sy_next     = sy_upd;
                            err_next    = e_upd;
                        end
                    end
                    default:
                    begin
                        ov_next = 1'b0;
                    end
                endcase
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            emit_reg   <= 1'b0;
            idx_reg    <= '0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            emit_reg   <= emit_next;
            idx_reg    <= idx_next;
            ov_reg     <= ov_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        cx_reg     <= cx_next;
        cy_reg     <= cy_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
        sx_reg     <= sx_next;
        sy_reg     <= sy_next;
        err_reg    <= err_next;
        d_reg      <= d_next;
        snap_x_reg <= snap_x_next;
        snap_y_reg <= snap_y_next;
        px_reg     <= px_next;
        py_reg     <= py_next;
        last_reg   <= last_next;
        fin_reg    <= fin_next;
    end

    assign out_valid = ov_reg;
    assign point_x   = px_reg;
    assign point_y   = py_reg;
    assign last      = last_reg;
    assign finished  = fin_reg;

endmodule

/* hw/rtl/midpoint_circle_point_generator_core.sv */
// Channel   Direction  Handshake              Payload
// config    in         cfg_we                 cfg_wdata (zoom)
// command   in         in_valid / in_stall    op, center_x, center_y, radius
// point     out        out_valid / out_stall  point_x, point_y, last, finished
//
// A step command puts eight points out, one point per cycle while out_stall is low;
// a finished step puts out one point with finished set, and a start command none.
// A two-entry command queue lets the front accept while the back drains points.
// Reset clears control state and sets zoom to 1.0; the circle starts inactive.
// A stalled point holds in the output register; the queue stalls the command side.
module midpoint_circle_point_generator_core
    import cpg_pkg::*;
#(
    parameter int ZOOM_FRAC_BITS = 8
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [Z_W-1:0]          cfg_wdata,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic                    op,
    input  logic signed [C_W-1:0]   center_x,
    input  logic signed [C_W-1:0]   center_y,
    input  logic [R_W-1:0]          radius,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic signed [PT_W-1:0]  point_x,
    output logic signed [PT_W-1:0]  point_y,
    output logic                    last,
    output logic                    finished
);

    q_stat_t  q_stat;
    logic     push;
    logic     pop;
    cmd_t     wr_cmd;
    cmd_t     rd_cmd;

    // Accept and scale commands
    cpg_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .op        (op),
        .center_x  (center_x),
        .center_y  (center_y),
        .radius    (radius),
        .q_stat    (q_stat),
        .push      (push),
        .wr_cmd    (wr_cmd)
    );

    // Buffer commands between front and back
    cpg_queue u_queue
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wr_cmd (wr_cmd),
        .pop    (pop),
        .rd_cmd (rd_cmd),
        .q_stat (q_stat)
    );

    // Walk the circle and emit points
    cpg_back #(
        .ZOOM_FRAC_BITS (ZOOM_FRAC_BITS)
    ) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_stat    (q_stat),
        .rd_cmd    (rd_cmd),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .point_x   (point_x),
        .point_y   (point_y),
        .last      (last),
        .finished  (finished)
    );

`ifndef SYNTH
    a_fin_is_last_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && finished) |-> (last && point_x == '0 && point_y == '0))
        else $error("finished result not last or not at origin");

    a_points_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !last) |=> out_valid)
        else $error("gap inside the points of one step");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.empty |-> !pop)
        else $error("command popped from empty queue");
`endif

endmodule
